// ===== hdl/u2u_pkg.sv =====
// Shared types, command codes and constants for the UTF-8 to UTF-16 transcoder.
package u2u_pkg;

    // Result status codes
    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_TERM = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Command kinds handed from the decoder to the result expander
    localparam logic [2:0] CMD_UNIT     = 3'd0;  // one code unit
    localparam logic [2:0] CMD_PAIR     = 3'd1;  // surrogate pair
    localparam logic [2:0] CMD_ERR      = 3'd2;  // error only
    localparam logic [2:0] CMD_ERR_TERM = 3'd3;  // error, then terminator
    localparam logic [2:0] CMD_TERM     = 3'd4;  // terminator only

    // Code point limits and surrogate bases
    localparam logic [20:0] ASCII_MAX    = 21'd127;
    localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
    localparam logic [20:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Default depth of the command queue between decoder and expander
    localparam int unsigned CMD_DEPTH_DEF = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] point;
    } t_cmd;

endpackage

// ===== hdl/u2u_front.sv =====
// Decoder: takes UTF-8 bytes, tracks the open sequence and issues result commands.
module u2u_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    output logic           o_cmd_valid,
    output u2u_pkg::t_cmd  o_cmd
);
    import u2u_pkg::*;

    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_accum, n_accum;
    logic [1:0]  r_seq_len, n_seq_len;
    logic        r_skip, n_skip;

    logic [20:0] acc_shift;
    logic [1:0]  pend_dec;

    assign acc_shift = {r_accum[14:0], i_in_byte[5:0]};
    assign pend_dec  = r_pending - 2'd1;

    // Decode one byte against the sequence state
    always_comb begin
        n_pending   = r_pending;
        n_accum     = r_accum;
        n_seq_len   = r_seq_len;
        n_skip      = r_skip;
        o_cmd_valid = 1'b0;
        o_cmd.kind  = CMD_UNIT;
        o_cmd.point = '0;
        if (i_accept) begin
            if (i_in_byte == 8'h00) begin
                // end of string: flag an open sequence, then terminate
                o_cmd_valid = 1'b1;
                o_cmd.kind  = (!r_skip && r_pending != 2'd0) ? CMD_ERR_TERM : CMD_TERM;
                n_pending   = '0;
                n_accum     = '0;
                n_seq_len   = '0;
                n_skip      = 1'b0;
            end else if (!r_skip) begin
                if (r_pending == 2'd0) begin
                    if (i_in_byte inside {[8'h00:8'h7F]}) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = CMD_UNIT;
                        o_cmd.point = {13'd0, i_in_byte};
                    end else if (i_in_byte inside {[8'hF0:8'hFF]}) begin
                        n_accum   = {18'd0, i_in_byte[2:0]};
                        n_pending = 2'd3;
                        n_seq_len = 2'd3;
                    end else if (i_in_byte inside {[8'hE0:8'hEF]}) begin
                        n_accum   = {17'd0, i_in_byte[3:0]};
                        n_pending = 2'd2;
                        n_seq_len = 2'd2;
                    end else if (i_in_byte inside {[8'hC0:8'hDF]}) begin
                        n_accum   = {16'd0, i_in_byte[4:0]};
                        n_pending = 2'd1;
                        n_seq_len = 2'd1;
                    end else begin
                        // stray continuation byte
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = CMD_ERR;
                        n_pending   = '0;
                        n_accum     = '0;
                        n_seq_len   = '0;
                        n_skip      = 1'b1;
                    end
                end else if (!i_in_byte[7]) begin
                    // bad continuation byte
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = CMD_ERR;
                    n_pending   = '0;
                    n_accum     = '0;
                    n_seq_len   = '0;
                    n_skip      = 1'b1;
                end else if (pend_dec != 2'd0) begin
                    n_accum   = acc_shift;
                    n_pending = pend_dec;
                end else begin
                    // sequence complete: check range and two-byte overlong form
                    n_pending   = '0;
                    n_accum     = '0;
                    n_seq_len   = '0;
                    o_cmd_valid = 1'b1;
                    o_cmd.point = acc_shift;
                    if ((r_seq_len == 2'd1 && acc_shift <= ASCII_MAX) ||
                        acc_shift > MAX_POINT) begin
                        o_cmd.kind  = CMD_ERR;
                        o_cmd.point = '0;
                        n_skip      = 1'b1;
                    end else if (acc_shift > BMP_MAX) begin
                        o_cmd.kind = CMD_PAIR;
                    end else begin
                        o_cmd.kind = CMD_UNIT;
                    end
                end
            end
        end
    end

    // Hold sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_accum   <= '0;
            r_seq_len <= '0;
            r_skip    <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
            r_seq_len <= n_seq_len;
            r_skip    <= n_skip;
        end
    end

endmodule

// ===== hdl/u2u_cmd_fifo.sv =====
// Short command queue between the decoder and the result expander.
module u2u_cmd_fifo #(
    parameter int unsigned DEPTH = u2u_pkg::CMD_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u2u_pkg::t_cmd  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nempty,
    output u2u_pkg::t_cmd  o_data
);
    import u2u_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_nempty = (r_count != '0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;
    assign o_data   = r_mem[r_rd_ptr];

    // Store the request at the write pointer
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/u2u_back.sv =====
// Result expander: turns each command into one or two results in an output register.
module u2u_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  u2u_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [15:0]    o_code_unit,
    output logic [1:0]     o_status,
    output logic           o_run_last
);
    import u2u_pkg::*;

    logic        r_valid;
    logic        r_phase;
    logic [15:0] r_code_unit;
    logic [1:0]  r_status;
    logic        r_run_last;

    logic        load;
    logic        two_part;
    logic [20:0] offset;
    logic [15:0] n_code_unit;
    logic [1:0]  n_status;
    logic        n_run_last;

    assign load     = i_cmd_valid && (!r_valid || i_pop);
    assign two_part = (i_cmd.kind == CMD_PAIR) || (i_cmd.kind == CMD_ERR_TERM);
    assign offset   = i_cmd.point - SUPP_BASE;
    assign o_cmd_pop = load && !(two_part && !r_phase);

    // Select the result for the current phase of the command
    always_comb begin
        n_code_unit = '0;
        n_status    = ST_DATA;
        n_run_last  = 1'b1;
        case (i_cmd.kind)
            CMD_UNIT: begin
                n_code_unit = i_cmd.point[15:0];
            end
            CMD_PAIR: begin
                if (!r_phase) begin
                    n_code_unit = HI_SURR_BASE + {6'd0, offset[19:10]};
                    n_run_last  = 1'b0;
                end else begin
                    n_code_unit = LO_SURR_BASE + {6'd0, offset[9:0]};
                end
            end
            CMD_ERR: begin
                n_status = ST_ERR;
            end
            CMD_ERR_TERM: begin
                if (!r_phase) begin
                    n_status   = ST_ERR;
                    n_run_last = 1'b0;
                end else begin
                    n_status = ST_TERM;
                end
            end
            CMD_TERM: begin
                n_status = ST_TERM;
            end
            default: begin
                n_status = ST_ERR;
            end
        endcase
    end

    // Advance phase and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= two_part && !r_phase;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the shown result until it is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code_unit <= n_code_unit;
            r_status    <= n_status;
            r_run_last  <= n_run_last;
        end
    end

    assign o_empty     = !r_valid;
    assign o_code_unit = r_code_unit;
    assign o_status    = r_status;
    assign o_run_last  = r_run_last;

endmodule

// ===== hdl/utf8_to_utf16_stream.sv =====
// UTF-8 to UTF-16 stream transcoder: top level.
//
// Usage:
//   Input side is a queue: drive i_in_byte and raise i_push; the byte is taken at
//   an edge where i_push is high and o_full is low. A zero byte ends the string.
//   Result side is a queue: while o_empty is low, o_code_unit, o_status and
//   o_run_last show the oldest result; raise i_pop to take it.
//   Each byte gives zero, one or two results; o_run_last marks the last of them.
//   Status: data unit, string terminator or encoding error; after an error the
//   bytes up to the next zero give no results.
// Timing:
//   The decoder handles one byte per cycle while the queue is not full, writing
//   a request into a CMD_DEPTH-entry queue; the expander emits one result per
//   cycle from it while i_pop is high. A byte's first result passes through the
//   queue and the output register. Sustained rate is one byte per cycle while i_pop
//   is high; a surrogate pair or an error before a terminator gives two results.
// Reset and stall:
//   Synchronous active-low reset clears sequence state, empties the queue and
//   clears the output valid flag. When the receiver stalls, the output holds,
//   the queue fills, and o_full rises to stop the sender.
module utf8_to_utf16_stream #(
    parameter int unsigned CMD_DEPTH = u2u_pkg::CMD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_in_byte,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [15:0] o_code_unit,
    output logic [1:0]  o_status,
    output logic        o_run_last
);
    import u2u_pkg::*;

    logic accept;
    logic fr_valid;
    t_cmd fr_cmd;
    logic q_full;
    logic q_nempty;
    t_cmd q_cmd;
    logic bk_pop;

    assign accept = i_push && !q_full;
    assign o_full = q_full;

    u2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .o_cmd_valid (fr_valid),
        .o_cmd       (fr_cmd)
    );

    u2u_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fr_valid),
        .i_data   (fr_cmd),
        .o_full   (q_full),
        .i_pop    (bk_pop),
        .o_nempty (q_nempty),
        .o_data   (q_cmd)
    );

    u2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_nempty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (bk_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_code_unit (o_code_unit),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== hdl/u2u_checker.sv =====
// Port-level checks on the transcoder's result stream, bound to the top level.
module u2u_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pop,
    input logic        o_empty,
    input logic [15:0] o_code_unit,
    input logic [1:0]  o_status,
    input logic        o_run_last
);
    import u2u_pkg::*;

    // Terminator is always the last result of its byte
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status == ST_TERM) |-> o_run_last)
        else $error("terminator not marked last");

    // Error and terminator results carry a zero unit
    a_ctrl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != ST_DATA) |-> (o_code_unit == 16'h0000))
        else $error("control result with nonzero unit");

    // A data unit that is not last is a high surrogate
    a_hi_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status == ST_DATA && !o_run_last) |->
        (o_code_unit[15:10] == 6'b110110))
        else $error("non-final data unit is not a high surrogate");

    // Taking a high surrogate shows its low surrogate next
    a_lo_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_status == ST_DATA && !o_run_last) |=>
        (!o_empty && o_status == ST_DATA && o_run_last &&
         o_code_unit[15:10] == 6'b110111))
        else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_stream u2u_checker u_checker (.*);

// ===== tb/tb_utf8_to_utf16_stream.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 stream transcoder.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_stream;
    import u2u_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int QUIET_FROM     = 1500;
    localparam int PRESSURE_AT    = 900;
    localparam int SETTLE_CYCLES  = 16;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DIR_ROWS       = 28;

    // One UTF-16 result as it leaves the block
    typedef struct packed {
        logic [15:0] unit;
        logic [1:0]  status;
        logic        last;
    } t_utf16_res;

    // Directed row: byte, whether its results are typed in, and those results
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        typed;
        logic [1:0]  n;
        logic [15:0] unit0;
        logic [1:0]  st0;
        logic [1:0]  st1;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{8'h41, 1'b1, 2'd1, 16'h0041, ST_DATA, ST_DATA},  // single-byte letter
        '{8'h7F, 1'b1, 2'd1, 16'h007F, ST_DATA, ST_DATA},  // top single byte
        '{8'h00, 1'b1, 2'd1, 16'h0000, ST_TERM, ST_DATA},  // plain terminator
        '{8'hC3, 1'b1, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'hA9, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'hED, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},  // surrogate value, unchecked
        '{8'hA0, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'h80, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'hF0, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},  // surrogate pair
        '{8'h9F, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'h98, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'h80, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'hC1, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},  // overlong two-byte
        '{8'hBF, 1'b1, 2'd1, 16'h0000, ST_ERR,  ST_DATA},
        '{8'h41, 1'b1, 2'd0, 16'h0000, ST_DATA, ST_DATA},  // dropped while skipping
        '{8'h00, 1'b1, 2'd1, 16'h0000, ST_TERM, ST_DATA},  // only terminator when skipping
        '{8'h80, 1'b1, 2'd1, 16'h0000, ST_ERR,  ST_DATA},  // stray continuation
        '{8'h00, 1'b1, 2'd1, 16'h0000, ST_TERM, ST_DATA},
        '{8'hFF, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},  // top lead, beyond range
        '{8'h80, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'h80, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},
        '{8'h80, 1'b1, 2'd1, 16'h0000, ST_ERR,  ST_DATA},
        '{8'h00, 1'b1, 2'd1, 16'h0000, ST_TERM, ST_DATA},
        '{8'hE0, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},  // bit 7 clear mid sequence
        '{8'h41, 1'b1, 2'd1, 16'h0000, ST_ERR,  ST_DATA},
        '{8'h00, 1'b1, 2'd1, 16'h0000, ST_TERM, ST_DATA},
        '{8'hC2, 1'b0, 2'd0, 16'h0000, ST_DATA, ST_DATA},  // zero inside a sequence
        '{8'h00, 1'b1, 2'd2, 16'h0000, ST_ERR,  ST_TERM}
    };

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_push    = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_pop     = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [15:0] o_code_unit;
    logic [1:0]  o_status;
    logic        o_run_last;

    // Decoder state mirrored by the predictor
    logic [1:0]  pend_cnt = 2'd0;
    logic [20:0] cp_acc   = 21'd0;
    logic [1:0]  seq_len  = 2'd0;
    logic        skipping = 1'b0;

    t_utf16_res  utf16_expect [$];
    t_utf16_res  byte_results [$];

    int  fail_count    = 0;
    int  items_done    = 0;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    bit  send_idle_on  = 1'b1;
    bit  pop_idle_on   = 1'b1;
    bit  pressure_done = 1'b0;

    utf8_to_utf16_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in_byte   (i_in_byte),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_code_unit (o_code_unit),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    function automatic void add_result(input logic [15:0] unit, input logic [1:0] st);
        t_utf16_res r;
        r.unit   = unit;
        r.status = st;
        r.last   = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void clear_seq();
        pend_cnt = 2'd0;
        cp_acc   = 21'd0;
        seq_len  = 2'd0;
    endfunction

    function automatic void flag_error();
        clear_seq();
        skipping = 1'b1;
        add_result(16'h0000, ST_ERR);
    endfunction

    // Split points above the BMP into a high/low surrogate pair
    function automatic void emit_point(input logic [20:0] point);
        logic [20:0] v;
        if (point > BMP_MAX) begin
            v = point - SUPP_BASE;
            add_result(HI_SURR_BASE + {6'd0, v[19:10]}, ST_DATA);
            add_result(LO_SURR_BASE + {6'd0, v[9:0]}, ST_DATA);
        end else begin
            add_result(point[15:0], ST_DATA);
        end
    endfunction

    // Advance the decoder by one byte and collect the results it causes
    function automatic void predict_byte(input logic [7:0] b);
        logic [20:0] point;
        t_utf16_res  r;
        byte_results.delete();
        if (b == 8'h00) begin
            if (!skipping && pend_cnt != 2'd0) add_result(16'h0000, ST_ERR);
            add_result(16'h0000, ST_TERM);
            clear_seq();
            skipping = 1'b0;
        end else if (skipping) begin
            // drop everything up to the next zero
        end else if (pend_cnt == 2'd0) begin
            if (!b[7]) begin
                emit_point({13'd0, b});
            end else if (b[7:4] == 4'hF) begin
                cp_acc   = {18'd0, b[2:0]};
                pend_cnt = 2'd3;
                seq_len  = 2'd3;
            end else if (b[7:5] == 3'b111) begin
                cp_acc   = {17'd0, b[3:0]};
                pend_cnt = 2'd2;
                seq_len  = 2'd2;
            end else if (b[7:6] == 2'b11) begin
                cp_acc   = {16'd0, b[4:0]};
                pend_cnt = 2'd1;
                seq_len  = 2'd1;
            end else begin
                flag_error();
            end
        end else if (!b[7]) begin
            flag_error();
        end else begin
            cp_acc   = {cp_acc[14:0], b[5:0]};
            pend_cnt = pend_cnt - 2'd1;
            if (pend_cnt == 2'd0) begin
                point = cp_acc;
                if ((seq_len == 2'd1 && point <= ASCII_MAX) || point > MAX_POINT) begin
                    flag_error();
                end else begin
                    clear_seq();
                    emit_point(point);
                end
            end
        end
        if (byte_results.size() > 0) begin
            r = byte_results[byte_results.size() - 1];
            r.last = 1'b1;
            byte_results[byte_results.size() - 1] = r;
        end
    endfunction

    // Offer one byte, hold it until taken, then predict its results
    task automatic send_byte(input logic [7:0] b, input bit typed);
        int gap;
        if (send_idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (b == 8'h00 || !skipping) items_done++;
        predict_byte(b);
        if (!typed) begin
            foreach (byte_results[k]) utf16_expect.push_back(byte_results[k]);
        end
    endtask

    // Encode a point with the given length; send fewer continuations to truncate
    task automatic send_point(input logic [20:0] cp, input int nbytes, input int ncont);
        logic [7:0] lead;
        logic [5:0] six;
        logic       spare;
        int         k;
        case (nbytes)
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'hE, cp[15:12]};
            default: lead = {($urandom_range(0, 7) == 0) ? 5'b11111 : 5'b11110, cp[20:18]};
        endcase
        send_byte(lead, 1'b0);
        for (k = 1; k <= ncont; k++) begin
            six   = 6'(cp >> (6 * (nbytes - 1 - k)));
            spare = ($urandom_range(0, 7) == 0);
            send_byte({1'b1, spare, six}, 1'b0);
        end
    endtask

    // Mostly well-formed strings, with some broken sequences and noise
    task automatic send_string();
        int         nchars;
        int         kind;
        int         nb;
        int         c;
        nchars = $urandom_range(1, 10);
        for (c = 0; c < nchars; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                send_byte(8'($urandom_range(1, 127)), 1'b0);
            end else if (kind < 50) begin
                send_point(21'($urandom_range(21'h80, 21'h7FF)), 2, 1);
            end else if (kind < 68) begin
                send_point(21'($urandom_range(0, 21'hFFFF)), 3, 2);
            end else if (kind < 85) begin
                send_point(21'($urandom_range(21'h10000, 21'h10FFFF)), 4, 3);
            end else if (kind < 89) begin
                send_point(21'($urandom_range(0, 127)), 2, 1);
            end else if (kind < 92) begin
                send_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 3);
            end else if (kind < 95) begin
                nb = $urandom_range(2, 4);
                send_point(21'($urandom), nb, $urandom_range(0, nb - 2));
            end else if (kind < 98) begin
                send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end else begin
                send_byte(8'($urandom_range(1, 255)), 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0) send_byte(8'h00, 1'b0);
    endtask

    // Hold the sender until every pending result has drained
    task automatic drain_results();
        i_push <= 1'b0;
        while (utf16_expect.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Result side: check each popped result, then pick the next pop value
    initial begin
        t_utf16_res want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) begin
                if (utf16_expect.size() == 0) begin
                    $error("unexpected result: code_unit %h status %0d run_last %0d",
                           o_code_unit, o_status, o_run_last);
                    fail_count++;
                end else begin
                    want = utf16_expect.pop_front();
                    if (o_code_unit !== want.unit) begin
                        $error("code_unit: expected %h, actual %h", want.unit, o_code_unit);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %0d, actual %0d", want.last, o_run_last);
                        fail_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_pop <= 1'b0;
            end else if (pop_idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 13);
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus: reset, directed table, then random strings
    initial begin
        t_dir_row   row;
        t_utf16_res r;
        int         i;
        int         k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TABLE[i];
            send_byte(row.in_byte, row.typed);
            if (row.typed) begin
                for (k = 0; k < int'(row.n); k++) begin
                    r.unit   = (k == 0) ? row.unit0 : 16'h0000;
                    r.status = (k == 0) ? row.st0 : row.st1;
                    r.last   = (k == int'(row.n) - 1);
                    utf16_expect.push_back(r);
                end
            end
        end
        drain_results();

        items_done = 0;
        while (items_done < RANDOM_ITEMS) begin
            if (items_done >= QUIET_FROM) begin
                send_idle_on = 1'b0;
                pop_idle_on  = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                send_idle_on = 1'($urandom_range(0, 1));
                pop_idle_on  = 1'($urandom_range(0, 1));
            end
            if (!pressure_done && items_done >= PRESSURE_AT) begin
                drain_results();
                pressure_done = 1'b1;
            end
            send_string();
        end
        i_push <= 1'b0;

        while (utf16_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
